/* src/hll_pkg.sv */
// ----------------------------------------------------------------------------
// hll_pkg: shared types and constants of the sketch update block
// Command codes, field widths and the seed write word used between modules.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int KEY_BITS    = 32;
    localparam int SEED_WORDS  = 32;
    localparam int SEED_IDX_W  = 5;
    localparam int ROW_FIELD_W = 2;
    localparam int POS_W       = 10;
    localparam int CELL_W      = 6;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int ROWS_CFG_W  = 3;
    localparam int ROW_MAX_W   = 4;

    localparam logic [CELL_W-1:0] RANK_ONE = CELL_W'(1);

    typedef enum logic [1:0] {
        CMD_LOAD_SEL = 2'd0,
        CMD_LOAD_UPD = 2'd1,
        CMD_INSERT   = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic                  sel_we;
        logic                  upd_we;
        logic [ROW_MAX_W-1:0]  row;
        logic [SEED_IDX_W-1:0] pos;
        logic [KEY_BITS-1:0]   data;
    } t_seed_wr;

endpackage

/* src/hll_hash_unit.sv */
// ----------------------------------------------------------------------------
// hll_hash_unit: seed stores and bit-serial H3 hash
// Holds select and update seed words; walks the 32 key bits, one seed word
// per cycle, folding both hashes in an XOR accumulator.
// ----------------------------------------------------------------------------
module hll_hash_unit #(
    parameter int ROWS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hll_pkg::t_seed_wr             i_wr,
    input  logic                          i_start,
    input  logic [(ROWS>1 ? $clog2(ROWS) : 1)-1:0] i_row,
    input  logic [hll_pkg::KEY_BITS-1:0]  i_key,
    output logic                          o_done,
    output logic [hll_pkg::KEY_BITS-1:0]  o_sel_hash,
    output logic [hll_pkg::KEY_BITS-1:0]  o_upd_hash
);
    import hll_pkg::*;

    localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * SEED_WORDS;
    localparam int SAW   = $clog2(DEPTH);

    logic [KEY_BITS-1:0]   r_sel_mem [DEPTH];
    logic [KEY_BITS-1:0]   r_upd_mem [DEPTH];
    logic [KEY_BITS-1:0]   r_sel_q;
    logic [KEY_BITS-1:0]   r_upd_q;
    logic [KEY_BITS-1:0]   r_key;
    logic [KEY_BITS-1:0]   r_sel_acc;
    logic [KEY_BITS-1:0]   r_upd_acc;
    logic [RIW-1:0]        r_row;
    logic [SEED_IDX_W-1:0] r_cnt;
    logic                  r_run;
    logic                  r_vld;
    logic                  r_take;
    logic                  r_done;
    logic [SAW-1:0]        w_waddr;
    logic [SAW-1:0]        w_raddr;

    assign w_waddr = SAW'({RIW'(i_wr.row), i_wr.pos});
    assign w_raddr = SAW'({r_row, r_cnt});

    always_ff @(posedge i_clk) begin
        if (i_wr.sel_we) begin
            r_sel_mem[w_waddr] <= i_wr.data;
        end
        if (r_run) begin
            r_sel_q <= r_sel_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.upd_we) begin
            r_upd_mem[w_waddr] <= i_wr.data;
        end
        if (r_run) begin
            r_upd_q <= r_upd_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_vld  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_vld  <= r_run;
            r_done <= r_vld && !r_run;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + SEED_IDX_W'(1);
                if (r_cnt == SEED_IDX_W'(SEED_WORDS - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key     <= i_key;
            r_row     <= i_row;
            r_sel_acc <= '0;
            r_upd_acc <= '0;
        end else begin
            if (r_run) begin
                r_take <= r_key[0];
                r_key  <= r_key >> 1;
            end
            if (r_vld && r_take) begin
                r_sel_acc <= r_sel_acc ^ r_sel_q;
                r_upd_acc <= r_upd_acc ^ r_upd_q;
            end
        end
    end

    assign o_done     = r_done;
    assign o_sel_hash = r_sel_acc;
    assign o_upd_hash = r_upd_acc;

endmodule

/* src/hll_mod_unit.sv */
// ----------------------------------------------------------------------------
// hll_mod_unit: iterative remainder and rank unit
// Restoring division, one quotient bit per cycle, gives hash mod columns;
// the same steps shift the update hash to count its leading zeros.
// ----------------------------------------------------------------------------
module hll_mod_unit #(
    parameter int CW = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hll_pkg::KEY_BITS-1:0]  i_dividend,
    input  logic [CW-1:0]                 i_divisor,
    input  logic [hll_pkg::KEY_BITS-1:0]  i_upd_hash,
    output logic                          o_done,
    output logic [CW-1:0]                 o_rem,
    output logic [hll_pkg::CELL_W-1:0]    o_rank
);
    import hll_pkg::*;

    logic [KEY_BITS-1:0]   r_dvd;
    logic [KEY_BITS-1:0]   r_uh;
    logic [CW-1:0]         r_div;
    logic [CW-1:0]         r_rem;
    logic [CELL_W-1:0]     r_rank;
    logic                  r_found;
    logic [SEED_IDX_W-1:0] r_cnt;
    logic                  r_run;
    logic                  r_done;
    logic [CW:0]           w_trial;
    logic [CW:0]           w_diff;

    assign w_trial = {r_rem, r_dvd[KEY_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + SEED_IDX_W'(1);
                if (r_cnt == SEED_IDX_W'(KEY_BITS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd   <= i_dividend;
            r_div   <= i_divisor;
            r_uh    <= i_upd_hash;
            r_rem   <= '0;
            r_rank  <= RANK_ONE;
            r_found <= 1'b0;
        end else if (r_run) begin
            r_dvd <= r_dvd << 1;
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[CW-1:0];
            end else begin
                r_rem <= w_trial[CW-1:0];
            end
            if (!r_found) begin
                if (r_uh[KEY_BITS-1]) begin
                    r_found <= 1'b1;
                end else begin
                    r_rank <= r_rank + RANK_ONE;
                end
            end
            r_uh <= r_uh << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_rank = r_rank;

endmodule

/* src/hyperloglog_sketch_update.sv */
// ----------------------------------------------------------------------------
// hyperloglog_sketch_update: multi-row sketch with H3 hashing
// Seed loads, key inserts and cell reads by command; one result word each.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result word is
// shown on o_cell_value and o_status for the single cycle that o_done is high,
// and the receiver cannot stall it. A seed load answers in the cycle after it
// is taken; a valid cell read is first registered from the store, then answered
// from S_CELL. An insert runs row by row through the bit-serial hash (one
// seed word read per cycle) and the shared remainder unit (one quotient bit
// per cycle), then a cell read and, if the new rank is larger, a cell write,
// for each row in use. After reset the sketch store is cleared one cell per
// cycle with busy high; configuration writes are taken throughout.
module hyperloglog_sketch_update #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hll_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hll_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_command,
    input  logic [hll_pkg::KEY_BITS-1:0]    i_key,
    input  logic [hll_pkg::ROW_FIELD_W-1:0] i_row,
    input  logic [hll_pkg::POS_W-1:0]       i_position,
    input  logic [hll_pkg::KEY_BITS-1:0]    i_seed_word,
    output logic                            o_done,
    output logic [hll_pkg::CELL_W-1:0]      o_cell_value,
    output logic                            o_status
);
    import hll_pkg::*;

    localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int NW    = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_RD,
        S_CELL
    } t_state;

    t_state                r_state;
    logic [CFG_DATA_W-1:0] r_column_count;
    logic [ROWS_CFG_W-1:0] r_rows_in_use;
    logic [AW-1:0]         r_clr;
    logic [AW-1:0]         r_base;
    logic [AW-1:0]         r_wr_addr;
    logic [RIW-1:0]        r_row;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_done;
    logic [CELL_W-1:0]     r_value;
    logic                  r_status;
    logic [CELL_W-1:0]     r_cells [DEPTH];
    logic [CELL_W-1:0]     r_rd_data;

    t_cmd                  w_cmd;
    logic                  w_accept;
    logic                  w_row_bad;
    logic [CW-1:0]         w_cols;
    logic [NW-1:0]         w_nrows;
    logic                  w_last_row;
    t_seed_wr              w_seed_wr;
    logic                  w_hash_start;
    logic                  w_hash_done;
    logic [KEY_BITS-1:0]   w_sel_hash;
    logic [KEY_BITS-1:0]   w_upd_hash;
    logic                  w_mod_done;
    logic [CW-1:0]         w_rem;
    logic [CELL_W-1:0]     w_rank;
    logic [AW-1:0]         w_cell_addr;
    logic [AW-1:0]         w_read_addr;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [CELL_W-1:0]     w_wr_data;

    assign w_cmd     = t_cmd'(i_command);
    assign w_accept  = start && !busy;
    assign w_row_bad = (32'(i_row) >= ROWS);

    always_comb begin
        if (r_column_count == '0) begin
            w_cols = CW'(1);
        end else if (32'(r_column_count) > COLUMNS) begin
            w_cols = CW'(COLUMNS);
        end else begin
            w_cols = CW'(r_column_count);
        end
        if (r_rows_in_use == '0) begin
            w_nrows = NW'(1);
        end else if (32'(r_rows_in_use) > ROWS) begin
            w_nrows = NW'(ROWS);
        end else begin
            w_nrows = NW'(r_rows_in_use);
        end
    end

    assign w_last_row = (32'(r_row) + 1 == 32'(w_nrows));

    always_comb begin
        w_seed_wr.sel_we = 1'b0;
        w_seed_wr.upd_we = 1'b0;
        w_seed_wr.row    = ROW_MAX_W'(i_row);
        w_seed_wr.pos    = i_position[SEED_IDX_W-1:0];
        w_seed_wr.data   = i_seed_word;
        if (w_accept && !w_row_bad && i_position[POS_W-1:SEED_IDX_W] == '0) begin
            w_seed_wr.sel_we = (w_cmd == CMD_LOAD_SEL);
            w_seed_wr.upd_we = (w_cmd == CMD_LOAD_UPD);
        end
    end

    assign w_hash_start = (r_state == S_IDLE && w_accept && w_cmd == CMD_INSERT)
                       || (r_state == S_RD && !w_last_row);

    hll_hash_unit #(
        .ROWS (ROWS)
    ) u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_seed_wr),
        .i_start    (w_hash_start),
        .i_row      ((r_state == S_RD) ? RIW'(r_row + RIW'(1)) : RIW'(0)),
        .i_key      ((r_state == S_IDLE) ? i_key : r_key),
        .o_done     (w_hash_done),
        .o_sel_hash (w_sel_hash),
        .o_upd_hash (w_upd_hash)
    );

    hll_mod_unit #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_HASH && w_hash_done),
        .i_dividend (w_sel_hash),
        .i_divisor  (w_cols),
        .i_upd_hash (w_upd_hash),
        .o_done     (w_mod_done),
        .o_rem      (w_rem),
        .o_rank     (w_rank)
    );

    assign w_cell_addr = AW'(32'(r_base) + 32'(COLW'(w_rem)));
    assign w_read_addr = AW'(32'(i_row) * COLUMNS + 32'(i_position));

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_read_addr;
        if (r_state == S_IDLE) begin
            w_rd_en = w_accept && w_cmd == CMD_READ && !w_row_bad
                   && 32'(i_position) < COLUMNS;
        end else if (r_state == S_MOD) begin
            w_rd_en   = w_mod_done;
            w_rd_addr = w_cell_addr;
        end
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = (r_state == S_RD) && (r_rd_data < w_rank);
            w_wr_addr = r_wr_addr;
            w_wr_data = w_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_cells[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_cells[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= CFG_DATA_W'(1024);
            r_rows_in_use  <= ROWS_CFG_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data;
                CFG_ROWS_IN_USE:  r_rows_in_use  <= i_cfg_data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_value  <= '0;
            r_status <= 1'b0;
            r_row    <= '0;
            r_base   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_value  <= '0;
                        r_status <= 1'b0;
                        unique case (w_cmd)
                            CMD_LOAD_SEL, CMD_LOAD_UPD: begin
                                r_done   <= 1'b1;
                                r_status <= w_row_bad
                                         || i_position[POS_W-1:SEED_IDX_W] != '0;
                            end
                            CMD_INSERT: begin
                                r_row   <= '0;
                                r_base  <= '0;
                                r_key   <= i_key;
                                r_state <= S_HASH;
                            end
                            CMD_READ: begin
                                if (w_rd_en) begin
                                    r_state <= S_CELL;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_status <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_wr_addr <= w_cell_addr;
                        r_state   <= S_RD;
                    end
                end
                S_RD: begin
                    if (w_last_row) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_row   <= r_row + RIW'(1);
                        r_base  <= AW'(32'(r_base) + COLUMNS);
                        r_state <= S_HASH;
                    end
                end
                S_CELL: begin
                    r_value <= r_rd_data;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_cell_value = r_value;
    assign o_status     = r_status;

endmodule

/* bench/tb_hyperloglog_sketch_update.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hyperloglog_sketch_update: command-level test of the sketch update block
// Seed loads, key inserts and cell reads are sent through the start/busy
// handshake with random idle bursts. A behavioral sketch in the bench tracks
// seeds, cells and both registers, predicts every result word and checks it
// against o_cell_value and o_status. The run walks through several register
// settings, including zero and out-of-range values, between idle points.
// ----------------------------------------------------------------------------
module tb_hyperloglog_sketch_update;

    import hll_pkg::*;

    localparam int ROWS          = 4;
    localparam int COLUMNS       = 1024;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        logic [1:0]  row;
        logic [9:0]  pos;
        logic [31:0] seed;
    } t_word;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic              status;
    } t_answer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_command = '0;
    logic [KEY_BITS-1:0]    i_key = '0;
    logic [ROW_FIELD_W-1:0] i_row = '0;
    logic [POS_W-1:0]       i_position = '0;
    logic [KEY_BITS-1:0]    i_seed_word = '0;
    logic                   o_done;
    logic [CELL_W-1:0]      o_cell_value;
    logic                   o_status;

    hyperloglog_sketch_update #(
        .ROWS(ROWS),
        .COLUMNS(COLUMNS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_key(i_key),
        .i_row(i_row),
        .i_position(i_position),
        .i_seed_word(i_seed_word),
        .o_done(o_done),
        .o_cell_value(o_cell_value),
        .o_status(o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_word   queued_commands[$];
    t_answer expected_words[$];
    t_word   on_port = '0;

    logic [31:0]       sel_seed [ROWS][SEED_WORDS];
    logic [31:0]       upd_seed [ROWS][SEED_WORDS];
    logic [CELL_W-1:0] cell_store [ROWS][COLUMNS];
    logic [10:0]       model_cols = 11'd1024;
    logic [2:0]        model_rows = 3'd4;

    bit          seed_planned [2][ROWS][SEED_WORDS];
    int unsigned plan_cols;
    int unsigned plan_rows;
    bit          gaps_enabled = 1'b0;
    int unsigned gap_left = 0;

    int unsigned n_loads = 0;
    int unsigned n_inserts = 0;
    int unsigned n_reads = 0;
    int unsigned n_hits = 0;
    int unsigned n_rejected = 0;
    int unsigned n_results = 0;
    int unsigned n_settings = 0;
    int unsigned mismatches = 0;

    function automatic int unsigned eff_cols(input logic [10:0] v);
        if (v == 0) return 1;
        if (v > COLUMNS) return COLUMNS;
        return v;
    endfunction

    function automatic int unsigned eff_rows(input logic [2:0] v);
        if (v == 0) return 1;
        if (v > ROWS) return ROWS;
        return v;
    endfunction

    function automatic logic [31:0] h3_fold(input logic [31:0] key, input int r,
                                            input bit use_update);
        logic [31:0] acc;
        acc = '0;
        for (int b = 0; b < KEY_BITS; b++) begin
            if (key[b]) acc ^= use_update ? upd_seed[r][b] : sel_seed[r][b];
        end
        return acc;
    endfunction

    function automatic logic [CELL_W-1:0] lead_rank(input logic [31:0] h);
        logic [CELL_W-1:0] n;
        n = RANK_ONE;
        for (int b = 31; b >= 0; b--) begin
            if (h[b]) return n;
            n++;
        end
        return n;
    endfunction

    function automatic t_answer sketch_apply(input t_word w);
        t_answer           ans;
        int unsigned       cols;
        int unsigned       nrows;
        int unsigned       col;
        logic [CELL_W-1:0] rk;
        ans = '0;
        case (w.cmd)
            CMD_LOAD_SEL, CMD_LOAD_UPD: begin
                n_loads++;
                if (int'(w.row) >= ROWS || w.pos >= SEED_WORDS) begin
                    ans.status = 1'b1;
                    n_rejected++;
                end else if (w.cmd == CMD_LOAD_SEL) begin
                    sel_seed[w.row][w.pos] = w.seed;
                end else begin
                    upd_seed[w.row][w.pos] = w.seed;
                end
            end
            CMD_INSERT: begin
                n_inserts++;
                cols  = eff_cols(model_cols);
                nrows = eff_rows(model_rows);
                for (int r = 0; r < nrows; r++) begin
                    col = h3_fold(w.key, r, 1'b0) % cols;
                    rk  = lead_rank(h3_fold(w.key, r, 1'b1));
                    if (cell_store[r][col] < rk) cell_store[r][col] = rk;
                end
            end
            default: begin
                n_reads++;
                if (int'(w.row) >= ROWS || w.pos >= COLUMNS) begin
                    ans.status = 1'b1;
                    n_rejected++;
                end else begin
                    ans.value = cell_store[w.row][w.pos];
                    if (ans.value != 0) n_hits++;
                end
            end
        endcase
        return ans;
    endfunction

    // driver: hold a word until taken, then idle for a burst when one is due
    always @(posedge i_clk) begin : drive
        t_word nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_words.push_back(sketch_apply(on_port));
            end
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    start <= 1'b0;
                    if (!busy) gap_left <= gap_left - 1;
                end else if (queued_commands.size() != 0) begin
                    nxt = queued_commands.pop_front();
                    on_port     <= nxt;
                    i_command   <= nxt.cmd;
                    i_key       <= nxt.key;
                    i_row       <= nxt.row;
                    i_position  <= nxt.pos;
                    i_seed_word <= nxt.seed;
                    start       <= 1'b1;
                    if (gaps_enabled && $urandom_range(0, 7) == 0) begin
                        gap_left <= $urandom_range(1, 17);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check
        t_answer want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_words.size() == 0) begin
                $error("unexpected result word: cell_value %0d, status %0b",
                       o_cell_value, o_status);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (o_cell_value !== want.value) begin
                    $error("cell_value: expected %0d, got %0d", want.value, o_cell_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_COLUMN_COUNT) model_cols = val;
        else if (idx == CFG_ROWS_IN_USE) model_rows = val[2:0];
    endtask

    task automatic drain();
        while (queued_commands.size() != 0 || start || expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [10:0] cols, input logic [2:0] rows);
        drain();
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_ROWS_IN_USE, {8'd0, rows});
        plan_cols = eff_cols(cols);
        plan_rows = eff_rows(rows);
        n_settings++;
    endtask

    task automatic queue_word(input t_cmd cmd, input logic [31:0] key,
                              input logic [1:0] row, input logic [9:0] pos,
                              input logic [31:0] seed);
        t_word w;
        w.cmd  = cmd;
        w.key  = key;
        w.row  = row;
        w.pos  = pos;
        w.seed = seed;
        if ((cmd == CMD_LOAD_SEL || cmd == CMD_LOAD_UPD) && pos < SEED_WORDS) begin
            seed_planned[cmd == CMD_LOAD_UPD][row][pos] = 1'b1;
        end
        queued_commands.push_back(w);
    endtask

    // small seed words give long runs of leading zeros, hence high ranks
    function automatic logic [31:0] seed_pattern();
        if ($urandom_range(0, 9) < 3) return $urandom >> $urandom_range(0, 31);
        return $urandom;
    endfunction

    task automatic queue_random_word();
        int unsigned pick;
        int unsigned b;
        logic [31:0] mask;
        logic [31:0] key;
        logic [9:0]  pos;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            pos = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
            queue_word(($urandom_range(0, 1) == 0) ? CMD_LOAD_SEL : CMD_LOAD_UPD,
                       $urandom, $urandom_range(0, 3), pos, seed_pattern());
        end else if (pick < 65) begin
            // use only seed words already loaded in every active row
            mask = '1;
            for (int r = 0; r < plan_rows; r++) begin
                for (int k = 0; k < SEED_WORDS; k++) begin
                    if (!seed_planned[0][r][k] || !seed_planned[1][r][k]) mask[k] = 1'b0;
                end
            end
            b = $urandom_range(0, 31);
            case ($urandom_range(0, 9))
                0: key = '0;
                1: key = mask[b] ? (32'd1 << b) : ($urandom & mask);
                default: key = $urandom & mask;
            endcase
            queue_word(CMD_INSERT, key, $urandom_range(0, 3), $urandom_range(0, 1023),
                       $urandom);
        end else begin
            pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, plan_cols - 1)
                                             : $urandom_range(0, 1023);
            queue_word(CMD_READ, $urandom, $urandom_range(0, 3), pos, $urandom);
        end
    endtask

    task automatic run_random(input int unsigned count, input bit gaps);
        gaps_enabled = gaps;
        repeat (count) queue_random_word();
    endtask

    initial begin
        for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < SEED_WORDS; k++) begin
                sel_seed[r][k] = '0;
                upd_seed[r][k] = '0;
            end
            for (int c = 0; c < COLUMNS; c++) cell_store[r][c] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_regs(11'd0, 3'd0);
        gaps_enabled = 1'b1;
        queue_word(CMD_INSERT, 32'h0000_0000, 2'd3, 10'd1023, 32'hFFFF_FFFF);
        queue_word(CMD_READ, 32'hFFFF_FFFF, 2'd0, 10'd0, 32'h0);
        queue_word(CMD_LOAD_SEL, 32'h0, 2'd0, 10'd5, 32'hFFFF_FFFF);
        queue_word(CMD_LOAD_UPD, 32'h0, 2'd0, 10'd5, 32'h0000_0001);
        queue_word(CMD_INSERT, 32'h0000_0020, 2'd0, 10'd0, 32'h0);
        queue_word(CMD_LOAD_SEL, 32'h0, 2'd0, 10'd31, 32'h0000_0000);
        queue_word(CMD_LOAD_UPD, 32'h0, 2'd0, 10'd31, 32'h8000_0000);
        queue_word(CMD_INSERT, 32'h8000_0020, 2'd0, 10'd0, 32'h0);
        queue_word(CMD_LOAD_SEL, 32'h0, 2'd0, 10'd32, 32'h1234_5678);
        queue_word(CMD_LOAD_UPD, 32'h0, 2'd3, 10'd1023, 32'hFFFF_FFFF);
        queue_word(CMD_LOAD_SEL, 32'h0, 2'd3, 10'd512, 32'h0);
        queue_word(CMD_READ, 32'h0, 2'd3, 10'd1023, 32'h0);
        queue_word(CMD_READ, 32'h0, 2'd1, 10'd0, 32'h0);
        queue_word(CMD_LOAD_SEL, 32'h0, 2'd0, 10'd0, 32'hFFFF_FFFF);
        queue_word(CMD_LOAD_UPD, 32'h0, 2'd0, 10'd0, 32'h0000_0000);
        queue_word(CMD_INSERT, 32'h0000_0001, 2'd0, 10'd0, 32'h0);
        queue_word(CMD_READ, 32'h0, 2'd0, 10'd0, 32'h0);
        queue_word(CMD_READ, 32'h0, 2'd0, 10'd1, 32'h0);

        // load every seed word of every row, then mix all commands
        set_regs(11'd2047, 3'd7);
        gaps_enabled = 1'b1;
        for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k < SEED_WORDS; k++) begin
                queue_word(CMD_LOAD_SEL, $urandom, r, k, seed_pattern());
                queue_word(CMD_LOAD_UPD, $urandom, r, k, seed_pattern());
            end
        end
        run_random(300, 1'b1);
        set_regs(11'd5, 3'd2);
        run_random(300, 1'b0);
        set_regs(11'd1, 3'd1);
        run_random(200, 1'b1);
        set_regs(11'd1024, 3'd4);
        run_random(300, 1'b1);
        set_regs(11'd37, 3'd3);
        run_random(300, 1'b1);
        set_regs(11'd1025, 3'd5);
        run_random(300, 1'b0);

        drain();
        $display("Covered %0d seed loads (%0d rejected), %0d inserts, %0d cell reads",
                 n_loads, n_rejected, n_inserts, n_reads);
        $display("over %0d register settings; %0d result words checked, %0d reads nonzero.",
                 n_settings, n_results, n_hits);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_hyperloglog_sketch_update passed");
        end else begin
            $display("tb_hyperloglog_sketch_update failed");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("tb_hyperloglog_sketch_update failed");
        $finish;
    end

endmodule

/* sim.f */
src/hll_pkg.sv
src/hll_hash_unit.sv
src/hll_mod_unit.sv
src/hyperloglog_sketch_update.sv
bench/tb_hyperloglog_sketch_update.sv
